[rtl/gbu_pkg.sv]
package gbu_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned DimW   = 16;
  localparam int unsigned CountW = 4;   // pixel count of one run, 1..8
  localparam int unsigned IdxW   = 3;   // pixel index within a run, 0..7

  localparam logic [1:0] RegInputFormat = 2'd0;
  localparam logic [1:0] RegImageWidth  = 2'd1;
  localparam logic [1:0] RegImageHeight = 2'd2;

  localparam logic FmtAscii  = 1'b0;
  localparam logic FmtBinary = 1'b1;

  localparam logic [ByteW-1:0] CharCr = 8'd13;
  localparam logic [ByteW-1:0] CharLf = 8'd10;
  localparam logic [ByteW-1:0] CharA  = 8'd65;
  // (byte - 'A' + 10) mod 16 equals the low nibble plus 9; '0' is 0 mod 16.
  localparam logic [3:0]       LetterOffset = 4'd9;

  localparam logic [CountW-1:0] MaxAscii  = 4'd4;
  localparam logic [CountW-1:0] MaxBinary = 4'd8;

  typedef struct packed {
    logic            fmt;
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic [DimW-1:0] col;
    logic [DimW-1:0] row;
    logic            pad;
    logic            done;
  } walk_t;

  typedef struct packed {
    logic              load;
    logic [ByteW-1:0]  bits;
    logic [CountW-1:0] count;
    logic [DimW-1:0]   col;
    logic [DimW-1:0]   row;
    logic              image_end;
  } run_t;

endpackage

[rtl/gbu_byte_decode.sv]
// Turns one byte and the current position into a run of up to eight pixels
// and the position that follows it.
module gbu_byte_decode (
  input  gbu_pkg::cfg_t               cfg_i,
  input  gbu_pkg::walk_t              walk_i,
  input  logic [gbu_pkg::ByteW-1:0]   data_byte_i,
  output gbu_pkg::walk_t              walk_o,
  output gbu_pkg::run_t               run_o
);

  logic                       ascii;
  logic                       empty;
  logic [gbu_pkg::DimW-1:0]   col0;
  logic [gbu_pkg::DimW-1:0]   row0;
  logic [gbu_pkg::DimW-1:0]   row1;
  logic [gbu_pkg::DimW-1:0]   remaining;
  logic [gbu_pkg::DimW-1:0]   col_end;
  logic [gbu_pkg::CountW-1:0] maxn;
  logic [gbu_pkg::CountW-1:0] n;
  logic [3:0]                 nibble;
  logic                       line_break;
  logic                       pad_width;

  assign ascii     = (cfg_i.fmt == gbu_pkg::FmtAscii);
  assign empty     = (cfg_i.width == '0) || (cfg_i.height == '0);
  assign col0      = (walk_i.col >= cfg_i.width) ? '0 : walk_i.col;
  assign row0      = (walk_i.col >= cfg_i.width) ? walk_i.row + 1'b1 : walk_i.row;
  assign row1      = row0 + 1'b1;
  assign remaining = cfg_i.width - col0;
  assign maxn      = ascii ? gbu_pkg::MaxAscii : gbu_pkg::MaxBinary;
  assign n         = (remaining < {{(gbu_pkg::DimW-gbu_pkg::CountW){1'b0}}, maxn}) ?
                     remaining[gbu_pkg::CountW-1:0] : maxn;
  assign col_end   = col0 + {{(gbu_pkg::DimW-gbu_pkg::CountW){1'b0}}, n};
  assign nibble    = (data_byte_i >= gbu_pkg::CharA) ?
                     data_byte_i[3:0] + gbu_pkg::LetterOffset : data_byte_i[3:0];
  assign line_break = (data_byte_i == gbu_pkg::CharCr) || (data_byte_i == gbu_pkg::CharLf);
  assign pad_width  = (cfg_i.width[2:0] >= 3'd1) && (cfg_i.width[2:0] <= 3'd4);

  always_comb begin
    walk_o          = walk_i;
    run_o.load      = 1'b0;
    run_o.bits      = ascii ? {4'd0, nibble} : data_byte_i;
    run_o.count     = n;
    run_o.col       = col0;
    run_o.row       = row0;
    run_o.image_end = 1'b0;
    if (!(walk_i.done || empty)) begin
      walk_o.col = col0;
      walk_o.row = row0;
      if (row0 >= cfg_i.height) begin
        walk_o.done = 1'b1;
      end else if (walk_i.pad) begin
        walk_o.pad = 1'b0;
      end else if (!(ascii && line_break)) begin
        run_o.load = 1'b1;
        if (col_end >= cfg_i.width) begin
          walk_o.col = '0;
          walk_o.row = row1;
          if (row1 >= cfg_i.height) begin
            walk_o.done     = 1'b1;
            run_o.image_end = 1'b1;
          end else if (ascii && pad_width) begin
            walk_o.pad = 1'b1;
          end
        end else begin
          walk_o.col = col_end;
        end
      end
    end
  end

endmodule

[rtl/grob_bitmap_unpacker_top.sv]
// The first pixel of a byte appears in the cycle after the byte is taken.
// A byte gives 1 to 8 pixels, which leave the run register one pixel per cycle
// while out_stall_i is low; a byte that gives no pixels leaves it empty.
// The next byte is taken in the cycle that the last pixel of a run leaves.
// Reset (rst_ni, asynchronous, active low) restores the default bitmap setup
// and returns the walk to row 0, column 0 with no run in flight.
module grob_bitmap_unpacker_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [1:0]                        cfg_index_i,
  input  logic [gbu_pkg::DimW-1:0]          cfg_data_i,
  // Input byte channel.
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [gbu_pkg::ByteW-1:0]         data_byte_i,
  // Pixel result channel.
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              ink_o,
  output logic [gbu_pkg::DimW-1:0]          column_o,
  output logic [gbu_pkg::DimW-1:0]          row_o,
  output logic                              last_of_run_o,
  output logic                              last_of_image_o
);

  gbu_pkg::cfg_t  cfg_q;
  gbu_pkg::walk_t walk_q, walk_d;
  gbu_pkg::run_t  run_d;

  // The run register holds the pixels of one byte and hands them out one per
  // beat, least significant bit first.
  logic                         run_valid_q;
  logic [gbu_pkg::ByteW-1:0]    bits_q;
  logic [gbu_pkg::CountW-1:0]   count_q;
  logic [gbu_pkg::IdxW-1:0]     idx_q;
  logic [gbu_pkg::DimW-1:0]     col_q;
  logic [gbu_pkg::DimW-1:0]     row_q;
  logic                         image_end_q;

  logic in_fire;
  logic out_fire;
  logic run_last;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fmt    <= gbu_pkg::FmtBinary;
      cfg_q.width  <= 16'd131;
      cfg_q.height <= 16'd64;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        gbu_pkg::RegInputFormat: cfg_q.fmt    <= cfg_data_i[0];
        gbu_pkg::RegImageWidth:  cfg_q.width  <= cfg_data_i;
        gbu_pkg::RegImageHeight: cfg_q.height <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gbu_byte_decode u_decode (
    .cfg_i       (cfg_q),
    .walk_i      (walk_q),
    .data_byte_i (data_byte_i),
    .walk_o      (walk_d),
    .run_o       (run_d)
  );

  // The last pixel of a run is the one whose index is count - 1.
  assign run_last = ({1'b0, idx_q} + 1'b1) == count_q;
  assign out_fire = run_valid_q && !out_stall_i;

  // A new byte is taken when the run register is empty or is being emptied.
  assign in_stall_o = run_valid_q && !(out_fire && run_last);
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q      <= '0;
      run_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (in_fire) begin
        walk_q <= walk_d;
      end
      if (in_fire) begin
        run_valid_q <= run_d.load;
        idx_q       <= '0;
      end else if (out_fire) begin
        // The last pixel can reach here only when no byte is offered, since the
        // input is not stalled then; handle both cases.
        if (run_last) begin
          run_valid_q <= 1'b0;
          idx_q       <= '0;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && run_d.load) begin
      bits_q      <= run_d.bits;
      count_q     <= run_d.count;
      col_q       <= run_d.col;
      row_q       <= run_d.row;
      image_end_q <= run_d.image_end;
    end else if (out_fire && !run_last) begin
      col_q <= col_q + 1'b1;
    end
  end

  assign out_valid_o     = run_valid_q;
  assign ink_o           = bits_q[idx_q];
  assign column_o        = col_q;
  assign row_o           = row_q;
  assign last_of_run_o   = run_last;
  assign last_of_image_o = image_end_q && run_last;

  // A byte may only enter over a full run register as its last pixel leaves.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && run_valid_q) |-> (out_fire && run_last))
    else $error("byte accepted over a run still in flight");

  // The pixel index never runs past the pixel count of the run.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_valid_q |-> (({1'b0, idx_q} < count_q) && (count_q != '0)))
    else $error("pixel index outside its run");

  // Once the final pixel of the image is delivered, the walk is marked done.
  a_done_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && last_of_image_o) |=> walk_q.done)
    else $error("image end delivered without the walk marked done");

  // After the last pixel of a run leaves with no new byte, the register is empty.
  a_run_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && run_last && !in_fire) |=> !run_valid_q)
    else $error("run register did not drain after its last pixel");

endmodule
